>>> rtl/core/radar_cone_gate_doppler_assert.svh
// assertion macros for the cone gate and doppler block
// no dependencies; included by the files that check their own logic
`ifndef RADAR_CONE_GATE_DOPPLER_ASSERT_SVH
`define RADAR_CONE_GATE_DOPPLER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RCGD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define RCGD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rcgd_pkg.sv
// shared types, constants and cordic / square root step functions
// for the cone gate and doppler block; no dependencies
package rcgd_pkg;

    // cordic and datapath sizing
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 32;
    localparam int VW                = 36;
    localparam int RW                = 34;
    localparam int SQW               = 64;
    localparam int SQRT_STEPS        = 32;
    localparam int PADDR_W           = 4;

    // rotation start value, 0.60725 in q30
    localparam logic signed [RW-1:0] ROT_GAIN = 34'sd652032874;

    // register reset values
    localparam logic [15:0]        AZ_HALF_RST = 16'd10923;
    localparam logic signed [15:0] EL_UPPER_RST = 16'sd16384;
    localparam logic signed [15:0] EL_LOWER_RST = -16'sd16384;
    localparam logic [31:0]        TWO_WL_RST   = 32'd33619968;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_AZ_HALF_RANGE,
        REG_ELEV_UPPER,
        REG_ELEV_LOWER,
        REG_TWO_OVER_WAVELENGTH
    } reg_index_t;

    // input beat
    typedef struct packed {
        logic signed [31:0] target_pos_x;
        logic signed [31:0] target_pos_y;
        logic signed [31:0] target_pos_z;
        logic signed [23:0] target_vel_x;
        logic signed [23:0] target_vel_y;
        logic signed [23:0] target_vel_z;
        logic signed [23:0] radar_vel_x;
    } target_t;

    // output beat
    typedef struct packed {
        logic               in_cone;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic signed [31:0] doppler_hz;
    } report_t;

    // vectoring cordic state
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          ang;
        logic                 zero;
    } vec_t;

    // rotation cordic state
    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
        logic                 flip;
    } rot_t;

    // square root state
    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [SQW-1:0] res;
    } sq_t;

    // velocity and height carried beside the angle work
    typedef struct packed {
        logic signed [31:0] pz;
        logic signed [23:0] tvx;
        logic signed [23:0] tvy;
        logic signed [23:0] tvz;
        logic signed [23:0] rvx;
    } side_t;

    // gate fields carried to the output
    typedef struct packed {
        logic               cone;
        logic signed [15:0] az;
        logic signed [15:0] el;
    } rep_t;

    // arctangent of 2^-i, 2^32 is a full turn
    localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h005171F1, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // fold into the right half plane before vectoring
    function automatic vec_t vec_pre(input logic signed [VW-1:0] px,
                                     input logic signed [VW-1:0] py);
        vec_t r;
        r.zero = (px == '0) && (py == '0);
        if (px < 0)
        begin
            r.x   = -px;
            r.y   = -py;
            r.ang = 32'h8000_0000;
        end
        else
        begin
            r.x   = px;
            r.y   = py;
            r.ang = '0;
        end
        return r;
    endfunction

    // one vectoring step, drives y towards zero
    function automatic vec_t vec_iter(input vec_t v, input int sh);
        vec_t r;
        r = v;
        if (v.y > 0)
        begin
            r.x   = v.x + (v.y >>> sh);
            r.y   = v.y - (v.x >>> sh);
            r.ang = v.ang + ATAN_TAB[sh[4:0]];
        end
        else
        begin
            r.x   = v.x - (v.y >>> sh);
            r.y   = v.y + (v.x >>> sh);
            r.ang = v.ang - ATAN_TAB[sh[4:0]];
        end
        return r;
    endfunction

    // round a full binary angle to 16 bits
    function automatic logic [15:0] angle16(input logic [31:0] a);
        logic [31:0] s;
        s = a + 32'h0000_8000;
        return s[31:16];
    endfunction

    // map a 16-bit angle into the right half plane for rotation
    function automatic rot_t rot_pre(input logic [15:0] a16);
        logic [31:0] th;
        logic [31:0] tq;
        rot_t        r;
        th     = {a16, 16'h0000};
        tq     = th + 32'h4000_0000;
        r.flip = tq[31];
        if (r.flip)
        begin
            th[31] = ~th[31];
        end
        r.z = RW'($signed(th));
        r.x = ROT_GAIN;
        r.y = '0;
        return r;
    endfunction

    // one rotation step, drives z towards zero
    function automatic rot_t rot_iter(input rot_t v, input int sh);
        logic signed [RW-1:0] a;
        rot_t                 r;
        a = $signed(RW'(ATAN_TAB[sh[4:0]]));
        r = v;
        if (v.z >= 0)
        begin
            r.x = v.x - (v.y >>> sh);
            r.y = v.y + (v.x >>> sh);
            r.z = v.z - a;
        end
        else
        begin
            r.x = v.x + (v.y >>> sh);
            r.y = v.y - (v.x >>> sh);
            r.z = v.z + a;
        end
        return r;
    endfunction

    // one restoring square root step, one result bit
    function automatic sq_t sqrt_iter(input sq_t s, input int step);
        logic [SQW-1:0] bit_v;
        logic [SQW-1:0] trial;
        sq_t            r;
        bit_v = SQW'(1) << (2 * SQRT_STEPS - 2 - 2 * step);
        trial = s.res + bit_v;
        if (s.rem >= trial)
        begin
            r.rem = s.rem - trial;
            r.res = (s.res >> 1) + bit_v;
        end
        else
        begin
            r.rem = s.rem;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/radar_cone_gate_doppler.sv
// top level: scan-cone gate and doppler frequency for one target per beat
// depends on rcgd_pkg and radar_cone_gate_doppler_assert.svh
//
//  channel   direction  handshake                    payload
//  target    in         target_valid / target_stall  rcgd_pkg::target_t
//  report    out        report_valid / report_stall  rcgd_pkg::report_t
//  config    in         apb psel/penable/pwrite      paddr, pwdata, prdata
//
// one target beat per cycle unless a stalled report holds the pipeline; the
// 32-step square root, the elevation vectoring cordic and the rotation
// cordic run one after another in the pipeline.
// rst_n clears the valid bits and the registers; data stages are not reset.
// a stalled report holds the whole pipeline, so nothing is lost or repeated.
`include "radar_cone_gate_doppler_assert.svh"

module radar_cone_gate_doppler #(
    parameter int CORDIC_STAGES = rcgd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         target_valid,
    output logic                         target_stall,
    input  rcgd_pkg::target_t            target_data,
    output logic                         report_valid,
    input  logic                         report_stall,
    output rcgd_pkg::report_t            report_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcgd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rcgd_pkg::*;

    // stage positions
    localparam int N        = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
    localparam int P_SUM    = 2;
    localparam int P_ROOT   = P_SUM + SQRT_STEPS;
    localparam int P_ELP    = P_ROOT + 1;
    localparam int P_AZ_END = 1 + N;
    localparam int AZ_DELAY = P_ELP + N - P_AZ_END;
    localparam int P_ANG    = P_ELP + N + 1;
    localparam int P_ROTP   = P_ANG + 1;
    localparam int P_MUL1   = P_ROTP + N + 1;
    localparam int P_GAIN   = P_MUL1 + 4;
    localparam int LAST     = P_GAIN + 1;

    // configuration registers
    logic [15:0]        az_half_reg;
    logic signed [15:0] el_upper_reg;
    logic signed [15:0] el_lower_reg;
    logic [31:0]        two_wl_reg;
    reg_index_t         cfg_idx;

    // pipeline control and data stages
    logic               advance;
    logic [LAST:0]      valid_reg;
    target_t            in_reg;
    side_t              side_reg [1:P_MUL1];
    logic [SQW-1:0]     sqx_reg;
    logic [SQW-1:0]     sqy_reg;
    sq_t                sq_reg   [0:SQRT_STEPS];
    vec_t               azv_reg  [0:N];
    logic [31:0]        azd_reg  [1:AZ_DELAY];
    vec_t               elv_reg  [0:N];
    rep_t               rep_reg  [P_ANG:P_GAIN];
    rot_t               rota_reg [0:N];
    rot_t               rote_reg [0:N];
    logic signed [2*RW-1:0] cc_prod_reg;
    logic signed [2*RW-1:0] cs_prod_reg;
    logic signed [RW-1:0]   se_reg;
    logic signed [24:0]     dv_reg;
    logic signed [58:0]     p1_reg;
    logic signed [57:0]     p2_reg;
    logic signed [57:0]     p3_reg;
    logic signed [61:0]     vr_reg;
    logic [39:0]            mag_reg;
    logic                   neg_mag_reg;
    logic [55:0]            m1_reg;
    logic [55:0]            m2_reg;
    logic                   neg_gain_reg;
    report_t                out_reg;

    // combinational helpers
    logic [31:0]          ax;
    logic [31:0]          ay;
    logic [31:0]          az_fin;
    logic [31:0]          el_ang;
    logic [31:0]          rh;
    logic signed [15:0]   az16;
    logic signed [16:0]   el_neg;
    logic signed [16:0]   el17;
    logic [16:0]          abs_az;
    logic                 cone;
    logic signed [RW-1:0] ca;
    logic signed [RW-1:0] sa;
    logic signed [RW-1:0] ce;
    logic signed [RW-1:0] se;
    logic signed [RW-1:0] cc;
    logic signed [RW-1:0] cs;
    logic signed [61:0]   vr_round;
    logic signed [39:0]   vr8;
    logic [56:0]          t_sum;
    logic [40:0]          fm;
    logic signed [31:0]   dop;
    logic [16:0]          rep_abs_az;
    logic                 beat_in;
    logic                 elev_ok;
    logic                 cone_ok;

    // apb register file
    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_half_reg  <= AZ_HALF_RST;
            el_upper_reg <= EL_UPPER_RST;
            el_lower_reg <= EL_LOWER_RST;
            two_wl_reg   <= TWO_WL_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                REG_AZ_HALF_RANGE:       az_half_reg  <= pwdata[15:0];
                REG_ELEV_UPPER:          el_upper_reg <= $signed(pwdata[15:0]);
                REG_ELEV_LOWER:          el_lower_reg <= $signed(pwdata[15:0]);
                REG_TWO_OVER_WAVELENGTH: two_wl_reg   <= pwdata;
                default:                 two_wl_reg   <= two_wl_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            REG_AZ_HALF_RANGE:       prdata = {16'h0000, az_half_reg};
            REG_ELEV_UPPER:          prdata = {16'h0000, el_upper_reg};
            REG_ELEV_LOWER:          prdata = {16'h0000, el_lower_reg};
            REG_TWO_OVER_WAVELENGTH: prdata = two_wl_reg;
            default:                 prdata = '0;
        endcase
    end

    // global pipeline enable: move unless the report is full and stalled
    assign advance      = !(valid_reg[LAST] && report_stall);
    assign target_stall = !advance;
    assign report_valid = valid_reg[LAST];
    assign report_data  = out_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAST-1:0], target_valid};
        end
    end

    // angle gate, rotation operands and doppler arithmetic
    always_comb
    begin
        ax     = in_reg.target_pos_x[31] ? 32'(-in_reg.target_pos_x) : in_reg.target_pos_x;
        ay     = in_reg.target_pos_y[31] ? 32'(-in_reg.target_pos_y) : in_reg.target_pos_y;
        az_fin = azv_reg[N].zero ? 32'h0 : azv_reg[N].ang;
        el_ang = elv_reg[N].zero ? 32'h0 : elv_reg[N].ang;
        rh     = sq_reg[SQRT_STEPS].res[31:0];

        az16   = $signed(angle16(azd_reg[AZ_DELAY]));
        el_neg = 17'sd0 - 17'($signed(angle16(el_ang)));
        if (el_neg > 17'sd16384)
        begin
            el17 = 17'sd16384;
        end
        else if (el_neg < -17'sd16384)
        begin
            el17 = -17'sd16384;
        end
        else
        begin
            el17 = el_neg;
        end
        abs_az = az16[15] ? (17'd0 - 17'(az16)) : 17'(az16);
        cone   = (abs_az <= {1'b0, az_half_reg})
              && (el17 <= 17'(el_upper_reg))
              && (el17 >= 17'(el_lower_reg));

        ca = rota_reg[N].flip ? -rota_reg[N].x : rota_reg[N].x;
        sa = rota_reg[N].flip ? -rota_reg[N].y : rota_reg[N].y;
        ce = rote_reg[N].flip ? -rote_reg[N].x : rote_reg[N].x;
        se = rote_reg[N].flip ? -rote_reg[N].y : rote_reg[N].y;
        cc = $signed(cc_prod_reg[RW+29:30]);
        cs = $signed(cs_prod_reg[RW+29:30]);

        vr_round = vr_reg + 62'sd2097152;
        vr8      = $signed(vr_round[61:22]);

        t_sum = {1'b0, m1_reg} + 57'(m2_reg >> 16);
        fm    = 41'((t_sum + 57'd32768) >> 16);
        if (neg_gain_reg)
        begin
            dop = (fm > 41'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'(41'd0 - fm));
        end
        else
        begin
            dop = (fm > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(fm[31:0]);
        end
    end

    // data stages, all held by a stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // input beat and carried fields
            in_reg      <= target_data;
            side_reg[1] <= '{pz: in_reg.target_pos_z, tvx: in_reg.target_vel_x,
                             tvy: in_reg.target_vel_y, tvz: in_reg.target_vel_z,
                             rvx: in_reg.radar_vel_x};
            for (int k = 2; k <= P_MUL1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            // horizontal range: squares, sum, then one root bit a stage
            sqx_reg   <= ax * ax;
            sqy_reg   <= ay * ay;
            sq_reg[0] <= '{rem: sqx_reg + sqy_reg, res: '0};
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                sq_reg[k] <= sqrt_iter(sq_reg[k-1], k - 1);
            end

            // azimuth vectoring, then delayed to meet the elevation
            azv_reg[0] <= vec_pre(VW'(in_reg.target_pos_y), VW'(in_reg.target_pos_x));
            for (int k = 1; k <= N; k++)
            begin
                azv_reg[k] <= vec_iter(azv_reg[k-1], k - 1);
            end
            azd_reg[1] <= az_fin;
            for (int k = 2; k <= AZ_DELAY; k++)
            begin
                azd_reg[k] <= azd_reg[k-1];
            end

            // elevation vectoring on range and height
            elv_reg[0] <= vec_pre($signed({{(VW-32){1'b0}}, rh}), VW'(side_reg[P_ROOT].pz));
            for (int k = 1; k <= N; k++)
            begin
                elv_reg[k] <= vec_iter(elv_reg[k-1], k - 1);
            end

            // gate and rounded angles
            rep_reg[P_ANG] <= '{cone: cone, az: az16, el: el17[15:0]};
            for (int k = P_ANG + 1; k <= P_GAIN; k++)
            begin
                rep_reg[k] <= rep_reg[k-1];
            end

            // cosine and sine of both output angles
            rota_reg[0] <= rot_pre(rep_reg[P_ANG].az);
            rote_reg[0] <= rot_pre(rep_reg[P_ANG].el);
            for (int k = 1; k <= N; k++)
            begin
                rota_reg[k] <= rot_iter(rota_reg[k-1], k - 1);
                rote_reg[k] <= rot_iter(rote_reg[k-1], k - 1);
            end

            // trig products
            cc_prod_reg <= ca * ce;
            cs_prod_reg <= ce * sa;
            se_reg      <= se;
            dv_reg      <= 25'(side_reg[P_MUL1-1].rvx) - 25'(side_reg[P_MUL1-1].tvx);

            // radial velocity terms and sum
            p1_reg <= dv_reg * cc;
            p2_reg <= side_reg[P_MUL1].tvy * cs;
            p3_reg <= side_reg[P_MUL1].tvz * se_reg;
            vr_reg <= 62'(p1_reg) - 62'(p2_reg) + 62'(p3_reg);

            // magnitude, then gain split into high and low halves
            neg_mag_reg  <= vr8[39];
            mag_reg      <= vr8[39] ? 40'(40'sd0 - vr8) : 40'(vr8);
            neg_gain_reg <= neg_mag_reg;
            m1_reg       <= mag_reg * two_wl_reg[31:16];
            m2_reg       <= mag_reg * two_wl_reg[15:0];

            // output register
            out_reg <= '{in_cone: rep_reg[P_GAIN].cone, azimuth: rep_reg[P_GAIN].az,
                         elevation: rep_reg[P_GAIN].el, doppler_hz: dop};
        end
    end

    // magnitude of the reported azimuth, for the gate check
    assign rep_abs_az = report_data.azimuth[15] ? (17'd0 - 17'(report_data.azimuth))
                                                : 17'(report_data.azimuth);

    // terms for the checks below
    assign beat_in = target_valid && !target_stall;
    assign elev_ok = (report_data.elevation <= 16'sd16384)
                  && (report_data.elevation >= -16'sd16384);
    assign cone_ok = !report_data.in_cone || (rep_abs_az <= 17'(az_half_reg));

    `RCGD_ASSERT_NEXT(a_accept_enters, clk, rst_n, beat_in, valid_reg[0], "accepted beat lost")
    `RCGD_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !advance, $stable(valid_reg), "valid moved")
    `RCGD_ASSERT_SAME(a_elev_range, clk, rst_n, report_valid, elev_ok, "elevation beyond clamp")
    `RCGD_ASSERT_SAME(a_cone_azimuth, clk, rst_n, report_valid, cone_ok, "cone flag off range")

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the scan-cone gate and doppler block
// depends on rcgd_pkg and radar_cone_gate_doppler; predicts each report in fixed point
`timescale 1ns / 100ps

module tb_top;
    import rcgd_pkg::*;

    localparam int STAGES   = CORDIC_STAGES_DEF;
    localparam int LATENCY  = 44 + 2 * STAGES;
    localparam int MAX_SHOW = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       target_valid = 1'b0;
    logic       target_stall;
    target_t    target_data = '0;
    logic       report_valid;
    logic       report_stall = 1'b0;
    report_t    report_data;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    // predictor copy of the registers
    logic [15:0]        cfg_az_half = AZ_HALF_RST;
    logic signed [15:0] cfg_el_upper = EL_UPPER_RST;
    logic signed [15:0] cfg_el_lower = EL_LOWER_RST;
    logic [31:0]        cfg_two_wl = TWO_WL_RST;

    report_t expected_reports [$];
    int      mismatches = 0;
    int      reports_seen = 0;
    int      targets_sent = 0;
    int      cone_hits = 0;
    bit      calm = 1'b0;
    bit      hold_req = 1'b0;
    bit      hold_seen = 1'b0;
    int      hold_left = 0;

    radar_cone_gate_doppler DUT (
        .clk(clk), .rst_n(rst_n),
        .target_valid(target_valid), .target_stall(target_stall), .target_data(target_data),
        .report_valid(report_valid), .report_stall(report_stall), .report_data(report_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // floor of the exact square root
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // vectoring cordic, full 32-bit binary angle of (x, y)
    function automatic logic [31:0] vector_angle(input longint x, input longint y);
        logic [31:0] ang;
        longint      dx;
        longint      dy;
        ang = '0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + ATAN_TAB[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - ATAN_TAB[i];
            end
        end
        return ang;
    endfunction

    function automatic logic signed [15:0] round_angle(input logic [31:0] a);
        logic [31:0] s;
        s = a + 32'h0000_8000;
        return s[31:16];
    endfunction

    // rotation cordic, cosine and sine in q30
    function automatic void cos_sin(input logic [15:0] a16, output longint c, output longint s);
        logic [31:0] th;
        logic [31:0] tq;
        logic        flip;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        th = {a16, 16'h0000};
        tq = th + 32'h4000_0000;
        flip = tq[31];
        if (flip)
            th = th - 32'h8000_0000;
        z = longint'($signed(th));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // expected report for one target
    function automatic report_t predict_report(input target_t t);
        longint          px, py, pz, tx, ty, tz, rx;
        longint unsigned ax, ay, fm, mag, tsum;
        longint          rh, az, el, abs_az, ca, sa, ce, se, cc, cs, vr, vr8, fd;
        report_t         r;
        px = t.target_pos_x;
        py = t.target_pos_y;
        pz = t.target_pos_z;
        tx = t.target_vel_x;
        ty = t.target_vel_y;
        tz = t.target_vel_z;
        rx = t.radar_vel_x;
        ax = px < 0 ? -px : px;
        ay = py < 0 ? -py : py;
        rh = longint'(int_sqrt(ax * ax + ay * ay));
        az = round_angle(vector_angle(py, px));
        el = -longint'(round_angle(vector_angle(rh, pz)));
        if (el > 16384)
            el = 16384;
        if (el < -16384)
            el = -16384;
        abs_az = az < 0 ? -az : az;
        r.in_cone = abs_az <= longint'({1'b0, cfg_az_half}) &&
                    el <= longint'(cfg_el_upper) && el >= longint'(cfg_el_lower);
        cos_sin(az[15:0], ca, sa);
        cos_sin(el[15:0], ce, se);
        cc = (ca * ce) >>> 30;
        cs = (ce * sa) >>> 30;
        vr = (rx - tx) * cc - ty * cs + tz * se;
        vr8 = (vr + (longint'(1) << 21)) >>> 22;
        mag = vr8 < 0 ? -vr8 : vr8;
        tsum = mag * (cfg_two_wl >> 16) + ((mag * cfg_two_wl[15:0]) >> 16);
        fm = (tsum + 32768) >> 16;
        if (vr8 < 0)
            fd = fm > 64'd2147483648 ? -longint'(64'd2147483648) : -longint'(fm);
        else
            fd = fm > 64'd2147483647 ? 64'sd2147483647 : longint'(fm);
        r.azimuth = az[15:0];
        r.elevation = el[15:0];
        r.doppler_hz = fd[31:0];
        return r;
    endfunction

    // register write, only while the block is idle
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_AZ_HALF_RANGE:       cfg_az_half = value[15:0];
            REG_ELEV_UPPER:          cfg_el_upper = value[15:0];
            REG_ELEV_LOWER:          cfg_el_lower = value[15:0];
            REG_TWO_OVER_WAVELENGTH: cfg_two_wl = value;
            default: ;
        endcase
    endtask

    // one target beat, with random gaps ahead of it
    task automatic send_target(input target_t t);
        while (!calm && $urandom_range(99) < 38)
        begin
            target_valid <= 1'b0;
            @(posedge clk);
        end
        target_valid <= 1'b1;
        target_data <= t;
        do
            @(posedge clk);
        while (target_stall);
        expected_reports.push_back(predict_report(t));
        targets_sent++;
    endtask

    // wait until every report is back and the pipe is empty
    task automatic drain;
        int guard;
        guard = 0;
        target_valid <= 1'b0;
        while (expected_reports.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic target_t make_target(input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z,
                                            input logic [23:0] vel);
        target_t t;
        t.target_pos_x = x;
        t.target_pos_y = y;
        t.target_pos_z = z;
        t.target_vel_x = vel;
        t.target_vel_y = -vel;
        t.target_vel_z = vel ^ 24'h5A5A5A;
        t.radar_vel_x = ~vel;
        return t;
    endfunction

    // mostly plausible geometry ahead of the antenna, some full-range noise
    function automatic target_t random_target;
        target_t t;
        int      span;
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(99) < 70)
        begin
            span = $urandom_range(24, 4);
            t.target_pos_x = $signed($urandom) >>> (32 - span);
            t.target_pos_y = $urandom >> (33 - span);
            t.target_pos_z = $signed($urandom) >>> (33 - span);
            if ($urandom_range(9) == 0)
                t.target_pos_y = -t.target_pos_y;
        end
        return t;
    endfunction

    // receiver: random stalls, calm stretches and a counted long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
            report_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            report_stall <= 1'b1;
        end
        else
            report_stall <= !calm && ($urandom_range(99) < 38);
    end

    // report checker
    always @(posedge clk)
    begin
        if (rst_n && report_valid && !report_stall)
        begin
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOW)
                    $display("unexpected report beat %p", report_data);
            end
            else
            begin
                report_t exp_r;
                exp_r = expected_reports.pop_front();
                if (report_data.in_cone) cone_hits++;
                if (report_data.in_cone !== exp_r.in_cone ||
                    report_data.azimuth !== exp_r.azimuth ||
                    report_data.elevation !== exp_r.elevation ||
                    report_data.doppler_hz !== exp_r.doppler_hz)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOW)
                        $display("report %0d: exp %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
                                 reports_seen, exp_r.in_cone, exp_r.azimuth,
                                 exp_r.elevation, exp_r.doppler_hz,
                                 report_data.in_cone, report_data.azimuth,
                                 report_data.elevation, report_data.doppler_hz);
                end
            end
        end
    end

    // corner geometry at the reset settings
    task automatic test_corners;
        send_target(make_target(0, 0, 0, 24'h000000));
        send_target(make_target(0, -1000, 0, 24'h7FFFFF));
        send_target(make_target(0, 32'sh8000_0000, 0, 24'h800000));
        send_target(make_target(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFFFFFF));
        send_target(make_target(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'h7FFFFF));
        send_target(make_target(0, 0, 32'sh7FFF_FFFF, 24'h800000));
        send_target(make_target(0, 0, 32'sh8000_0000, 24'h123456));
        send_target(make_target(1, 0, -1, 24'h000001));
        send_target(make_target(-1, 0, 1, 24'hFFFFFF));
        send_target(make_target(100, 25600, -50, 24'h0A0000));
        send_target(make_target(-25600, 25600, 0, 24'h7FFFFF));
        drain();
    endtask

    // extreme register settings: full and zero cone, empty window, gain extremes
    task automatic test_register_extremes;
        write_reg(REG_AZ_HALF_RANGE, 32'd32768);
        write_reg(REG_TWO_OVER_WAVELENGTH, 32'hFFFF_FFFF);
        send_target(make_target(0, -5000, 0, 24'h7FFFFF));
        send_target(make_target(3000, 100, 200, 24'h800000));
        send_target(make_target(32'sh8000_0000, 0, 0, 24'h7FFFFF));
        drain();
        write_reg(REG_AZ_HALF_RANGE, 32'd0);
        write_reg(REG_ELEV_UPPER, 32'h0000_C000);
        write_reg(REG_ELEV_LOWER, 32'h0000_4000);
        write_reg(REG_TWO_OVER_WAVELENGTH, 32'd0);
        send_target(make_target(0, 5000, 0, 24'h400000));
        send_target(make_target(0, 5000, -5000, 24'hC00000));
        drain();
        write_reg(REG_ELEV_UPPER, 32'd0);
        write_reg(REG_ELEV_LOWER, 32'd0);
        write_reg(REG_TWO_OVER_WAVELENGTH, 32'h0001_0000);
        send_target(make_target(0, 5000, 0, 24'h400000));
        send_target(make_target(0, 5000, 10, 24'h3FFFFF));
        drain();
    endtask

    // random targets over several register settings
    task automatic test_random;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_AZ_HALF_RANGE, $urandom_range(32768));
            write_reg(REG_ELEV_UPPER, 32'($signed($urandom_range(32768)) - 16384));
            write_reg(REG_ELEV_LOWER, 32'($signed($urandom_range(16384)) - 16384));
            write_reg(REG_TWO_OVER_WAVELENGTH, phase == 0 ? TWO_WL_RST : $urandom);
            calm = (phase == 2);
            for (int n = 0; n < 160; n++)
                send_target(random_target());
            calm = 1'b0;
            drain();
        end
    endtask

    // receiver holds off while targets keep coming, so the pipe backs up
    task automatic test_backpressure;
        calm = 1'b1;
        hold_req = ~hold_req;
        for (int n = 0; n < 200; n++)
            send_target(random_target());
        calm = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_corners();
        test_register_extremes();
        test_random();
        test_backpressure();
        $display("sent %0d targets, checked %0d reports (%0d inside the cone), %0d mismatches",
                 targets_sent, reports_seen, cone_hits, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("timeout with %0d reports outstanding", expected_reports.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rcgd_pkg.sv
rtl/core/radar_cone_gate_doppler.sv
tb/sv/tb_top.sv
